FILE: hw/rtl/hapg_pkg.sv
// shared types, constants and the microcode program of the hopalong point generator
// used by hapg_isqrt and hopalong_attractor_point_generator; no dependencies
`default_nettype none

package hapg_pkg;

   localparam int ScreenWidthDefault  = 1000;
   localparam int ScreenHeightDefault = 650;

   // 1.0 in Q16.16
   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   localparam logic signed [31:0] RESET_COEF_A      = 32'sd54510;
   localparam logic signed [31:0] RESET_COEF_B      = 32'sd868165;
   localparam logic signed [31:0] RESET_COEF_C      = 32'sd725541;
   localparam logic [3:0]         RESET_PIXEL_SCALE = 4'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_COEF_A      = 2'd0;
   localparam logic [1:0] CSR_COEF_B      = 2'd1;
   localparam logic [1:0] CSR_COEF_C      = 2'd2;
   localparam logic [1:0] CSR_PIXEL_SCALE = 2'd3;

   localparam int RadW  = 64;
   localparam int RootW = 32;
   localparam int IterW = 5;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_MUL,
      OP_RAD,
      OP_SQRT,
      OP_XUPD,
      OP_LOADONE,
      OP_PIXM,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_RESTART,
      CND_ITER_LEFT,
      CND_RSP_BUSY
   } cond_type;

   typedef logic [2:0] pc_type;

   localparam pc_type PC_WAIT    = 3'd0;
   localparam pc_type PC_MUL     = 3'd1;
   localparam pc_type PC_RAD     = 3'd2;
   localparam pc_type PC_SQRT    = 3'd3;
   localparam pc_type PC_XUPD    = 3'd4;
   localparam pc_type PC_LOADONE = 3'd5;
   localparam pc_type PC_PIXM    = 3'd6;
   localparam pc_type PC_EMIT    = 3'd7;

   // hold: stay on this step; jump: go to target; otherwise fall through
   typedef struct packed {
      op_type   op;
      cond_type hold;
      cond_type jump;
      pc_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic load;
      logic step;
   } sqrt_ctrl_type;

   function automatic ctrl_word_type ucode_rom(pc_type pc);
      ctrl_word_type w;
      unique case (pc)
         PC_WAIT:    w = '{OP_WAIT,    CND_NO_REQ,    CND_RESTART, PC_LOADONE};
         PC_MUL:     w = '{OP_MUL,     CND_NEVER,     CND_NEVER,   PC_WAIT};
         PC_RAD:     w = '{OP_RAD,     CND_NEVER,     CND_NEVER,   PC_WAIT};
         PC_SQRT:    w = '{OP_SQRT,    CND_ITER_LEFT, CND_NEVER,   PC_WAIT};
         PC_XUPD:    w = '{OP_XUPD,    CND_NEVER,     CND_ALWAYS,  PC_PIXM};
         PC_LOADONE: w = '{OP_LOADONE, CND_NEVER,     CND_NEVER,   PC_WAIT};
         PC_PIXM:    w = '{OP_PIXM,    CND_NEVER,     CND_NEVER,   PC_WAIT};
         PC_EMIT:    w = '{OP_EMIT,    CND_RSP_BUSY,  CND_ALWAYS,  PC_WAIT};
         default:    w = '{OP_WAIT,    CND_NO_REQ,    CND_RESTART, PC_LOADONE};
      endcase
      return w;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hapg_isqrt.sv
// bit-serial integer square root, one root bit per step over a 64-bit radicand
// depends on hapg_pkg for widths and the control struct
`default_nettype none

module hapg_isqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hapg_pkg::sqrt_ctrl_type   ctrl,
   input  wire logic [hapg_pkg::RadW-1:0] radicand,
   output logic [hapg_pkg::RootW-1:0]     root,
   output logic                           iter_left
);

   localparam int RemW = hapg_pkg::RootW + 2;

   logic [hapg_pkg::RadW-1:0]  rad_ff,  rad_in;
   logic [RemW-1:0]            rem_ff,  rem_in;
   logic [hapg_pkg::RootW-1:0] root_ff, root_in;
   logic [hapg_pkg::IterW-1:0] cnt_ff,  cnt_in;

   logic [RemW+1:0] rem_sh;
   logic [RemW+1:0] trial;
   logic [RemW+1:0] diff;
   logic            fits;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[hapg_pkg::RadW-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      diff   = rem_sh - trial;
      fits   = (rem_sh >= trial);

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (ctrl.load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '1;
      end else if (ctrl.step) begin
         rad_in  = {rad_ff[hapg_pkg::RadW-3:0], 2'b00};
         rem_in  = fits ? diff[RemW-1:0] : rem_sh[RemW-1:0];
         root_in = {root_ff[hapg_pkg::RootW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign iter_left = (cnt_ff != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/hopalong_attractor_point_generator.sv
// hopalong attractor point generator: microcoded sequencer over a multiply/add datapath
// step item: multiply, radicand load, the 32-step bit-serial square root, point update,
// pixel multiply, emit; restart item: point load to (1.0, 1.0), pixel multiply, emit
// emit holds while the previous result is stalled; no item is taken until the result is loaded
// reset: point (1.0, 1.0), coefficients to their defaults, sequencer waits for an item
// depends on hapg_pkg and hapg_isqrt
`default_nettype none

module hopalong_attractor_point_generator #(
   parameter int SCREEN_WIDTH  = hapg_pkg::ScreenWidthDefault,
   parameter int SCREEN_HEIGHT = hapg_pkg::ScreenHeightDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_restart,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_point_x,
   output logic signed [31:0]      rsp_point_y,
   output logic [10:0]             rsp_pixel_col,
   output logic [10:0]             rsp_pixel_row,
   output logic                    rsp_on_screen,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   localparam logic signed [21:0] EXT_W  = 22'(SCREEN_WIDTH);
   localparam logic signed [21:0] EXT_H  = 22'(SCREEN_HEIGHT);
   localparam logic signed [21:0] HALF_W = 22'(SCREEN_WIDTH / 2);
   localparam logic signed [21:0] HALF_H = 22'(SCREEN_HEIGHT / 2);

   // configuration
   logic signed [31:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic [3:0]         scale_ff;

   // sequencer
   hapg_pkg::pc_type        pc_ff, pc_in;
   hapg_pkg::ctrl_word_type word;
   logic                    hold_hit, jump_hit;

   // datapath
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [63:0] prod_ff;
   logic signed [31:0] ny_ff;
   logic signed [36:0] pxp_ff, pyp_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      out_x_ff, out_y_ff;
   logic [10:0]             out_col_ff, out_row_ff;
   logic                    out_on_ff;

   logic                    rsp_busy;
   hapg_pkg::sqrt_ctrl_type sq_ctrl;
   logic [63:0]             sq_rad;
   logic [31:0]             sq_root;
   logic                    sq_iter_left;

   logic signed [49:0] t_val;
   logic [49:0]        t_mag;
   logic signed [34:0] nx_val;
   logic signed [33:0] ny_val;
   logic signed [21:0] col_val, row_val;
   logic               on_x, on_y;

   function automatic logic cond_hit(hapg_pkg::cond_type c, logic no_req, logic restart,
                                     logic iter, logic busy);
      logic r;
      unique case (c)
         hapg_pkg::CND_NEVER:     r = 1'b0;
         hapg_pkg::CND_ALWAYS:    r = 1'b1;
         hapg_pkg::CND_NO_REQ:    r = no_req;
         hapg_pkg::CND_RESTART:   r = restart;
         hapg_pkg::CND_ITER_LEFT: r = iter;
         hapg_pkg::CND_RSP_BUSY:  r = busy;
         default:                 r = 1'b0;
      endcase
      return r;
   endfunction

   hapg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sq_ctrl),
      .radicand  (sq_rad),
      .root      (sq_root),
      .iter_left (sq_iter_left)
   );

   always_comb begin
      word      = hapg_pkg::ucode_rom(pc_ff);
      rsp_busy  = rsp_valid_ff & rsp_stall;
      hold_hit  = cond_hit(word.hold, !req_valid, req_restart, sq_iter_left, rsp_busy);
      jump_hit  = cond_hit(word.jump, !req_valid, req_restart, sq_iter_left, rsp_busy);
      if (hold_hit) begin
         pc_in = pc_ff;
      end else if (jump_hit) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
      req_stall = (word.op != hapg_pkg::OP_WAIT);
   end

   // radicand |floor(b*x) - 1 - c| scaled by 2^16; its magnitude stays below 2^48
   always_comb begin
      t_val = 50'($signed(prod_ff[63:16])) - 50'(hapg_pkg::ONE_Q16) - 50'(coef_c_ff);
      t_mag = t_val[49] ? 50'(-t_val) : 50'(t_val);
      sq_rad = {t_mag[47:0], 16'h0000};
      sq_ctrl.load = (word.op == hapg_pkg::OP_RAD);
      sq_ctrl.step = (word.op == hapg_pkg::OP_SQRT);
   end

   always_comb begin
      nx_val = 35'(y_ff) - 35'(hapg_pkg::ONE_Q16);
      if (x_ff > hapg_pkg::ONE_Q16) begin
         nx_val = nx_val - 35'(sq_root);
      end else if (x_ff < hapg_pkg::ONE_Q16) begin
         nx_val = nx_val + 35'(sq_root);
      end
      ny_val = 34'(coef_a_ff) - 34'(x_ff) - 34'(hapg_pkg::ONE_Q16);

      x_in = x_ff;
      y_in = y_ff;
      if (word.op == hapg_pkg::OP_XUPD) begin
         x_in = hapg_pkg::sat32(nx_val);
         y_in = ny_ff;
      end else if (word.op == hapg_pkg::OP_LOADONE) begin
         x_in = hapg_pkg::ONE_Q16;
         y_in = hapg_pkg::ONE_Q16;
      end
   end

   // floor(v*scale) + extent/2, checked against the screen
   always_comb begin
      col_val = 22'($signed(pxp_ff[36:16])) + HALF_W;
      row_val = 22'($signed(pyp_ff[36:16])) + HALF_H;
      on_x    = !col_val[21] && (col_val < EXT_W);
      on_y    = !row_val[21] && (row_val < EXT_H);
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (word.op == hapg_pkg::OP_EMIT && !rsp_busy) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= hapg_pkg::PC_WAIT;
         rsp_valid_ff <= 1'b0;
         x_ff         <= hapg_pkg::ONE_Q16;
         y_ff         <= hapg_pkg::ONE_Q16;
         coef_a_ff    <= hapg_pkg::RESET_COEF_A;
         coef_b_ff    <= hapg_pkg::RESET_COEF_B;
         coef_c_ff    <= hapg_pkg::RESET_COEF_C;
         scale_ff     <= hapg_pkg::RESET_PIXEL_SCALE;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               hapg_pkg::CSR_COEF_A:      coef_a_ff <= csr_data;
               hapg_pkg::CSR_COEF_B:      coef_b_ff <= csr_data;
               hapg_pkg::CSR_COEF_C:      coef_c_ff <= csr_data;
               hapg_pkg::CSR_PIXEL_SCALE: scale_ff  <= csr_data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (word.op)
         hapg_pkg::OP_MUL: begin
            prod_ff <= coef_b_ff * x_ff;
            ny_ff   <= hapg_pkg::sat32(35'(ny_val));
         end
         hapg_pkg::OP_PIXM: begin
            pxp_ff <= 37'(x_ff) * $signed({1'b0, scale_ff});
            pyp_ff <= 37'(y_ff) * $signed({1'b0, scale_ff});
         end
         hapg_pkg::OP_EMIT: begin
            if (!rsp_busy) begin
               out_x_ff   <= x_ff;
               out_y_ff   <= y_ff;
               out_col_ff <= (on_x && on_y) ? col_val[10:0] : 11'd0;
               out_row_ff <= (on_x && on_y) ? row_val[10:0] : 11'd0;
               out_on_ff  <= on_x && on_y;
            end
         end
         default: ;
      endcase
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_point_x   = out_x_ff;
   assign rsp_point_y   = out_y_ff;
   assign rsp_pixel_col = out_col_ff;
   assign rsp_pixel_row = out_row_ff;
   assign rsp_on_screen = out_on_ff;

endmodule

`default_nettype wire

FILE: tb/hopalong_attractor_point_generator_tb.sv
// self-checking testbench for the hopalong attractor point generator: directed table, then
// random orbits under many coefficient settings, each checked against an in-bench predictor
// depends on hapg_pkg and the hopalong_attractor_point_generator rtl
module hopalong_attractor_point_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 800000;
   localparam int RANDOM_ITEMS = 1350;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [10:0]        pixel_col;
      logic [10:0]        pixel_row;
      logic               on_screen;
   } pixel_point_type;

   typedef enum logic [0:0] {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic            restart;
      logic [1:0]      csr_idx;
      logic [31:0]     csr_val;
      logic            typed;
      pixel_point_type rsp;
   } dir_row_type;

   typedef enum {SET_NEAR, SET_WILD, SET_EDGE} setting_kind_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // point (1.0, 1.0) at scale 1 lands one pixel right of and below the center
   localparam pixel_point_type HOME_PT = '{32'sd65536, 32'sd65536, 11'd501, 11'd326, 1'b1};

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic [10:0]        rsp_pixel_col;
   logic [10:0]        rsp_pixel_row;
   logic               rsp_on_screen;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = hapg_pkg::CSR_COEF_A;
   logic [31:0]        csr_data = '0;

   // predictor copy of the configuration and the orbit
   logic signed [31:0] set_a = hapg_pkg::RESET_COEF_A;
   logic signed [31:0] set_b = hapg_pkg::RESET_COEF_B;
   logic signed [31:0] set_c = hapg_pkg::RESET_COEF_C;
   logic [3:0]         set_scale = hapg_pkg::RESET_PIXEL_SCALE;
   logic signed [31:0] orbit_x = hapg_pkg::ONE_Q16;
   logic signed [31:0] orbit_y = hapg_pkg::ONE_Q16;

   pixel_point_type pending_points[$];
   dir_row_type     dir_rows[$];

   int errors = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int restarts_sent = 0;
   int settings_tried = 0;
   int results_checked = 0;
   int on_screen_seen = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int mode_left = 0;

   hopalong_attractor_point_generator u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_pixel_row (rsp_pixel_row),
      .rsp_on_screen (rsp_on_screen),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -longint'(64'sh8000_0000)) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // bit-by-bit truncated square root, root stays below 2^32
   function automatic bit [63:0] int_sqrt(bit [63:0] n);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= n) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic bit screen_coord(input logic signed [31:0] v, input longint extent,
                                       output logic [10:0] pix);
      longint p;
      p = ((longint'(v) * longint'(set_scale)) >>> 16) + extent / 2;
      pix = p[10:0];
      return (p >= 0 && p < extent);
   endfunction

   function automatic pixel_point_type next_orbit_point(bit rst);
      longint          t;
      longint          nx;
      longint          ny;
      bit [63:0]       mag;
      bit [63:0]       root;
      logic [10:0]     cx;
      logic [10:0]     cy;
      bit              on_x;
      bit              on_y;
      pixel_point_type r;
      if (rst) begin
         orbit_x = hapg_pkg::ONE_Q16;
         orbit_y = hapg_pkg::ONE_Q16;
      end else begin
         t = ((longint'(set_b) * longint'(orbit_x)) >>> 16) - longint'(hapg_pkg::ONE_Q16)
             - longint'(set_c);
         mag = (t < 0) ? -t : t;
         root = int_sqrt(mag << 16);
         nx = longint'(orbit_y) - longint'(hapg_pkg::ONE_Q16);
         // sign of (x - 1) picks the direction; exactly 1.0 drops the root
         if (orbit_x > hapg_pkg::ONE_Q16) begin
            nx = nx - longint'(root);
         end else if (orbit_x < hapg_pkg::ONE_Q16) begin
            nx = nx + longint'(root);
         end
         ny = longint'(set_a) - longint'(orbit_x) - longint'(hapg_pkg::ONE_Q16);
         orbit_x = clamp32(nx);
         orbit_y = clamp32(ny);
      end
      on_x = screen_coord(orbit_x, hapg_pkg::ScreenWidthDefault, cx);
      on_y = screen_coord(orbit_y, hapg_pkg::ScreenHeightDefault, cy);
      r.point_x = orbit_x;
      r.point_y = orbit_y;
      r.on_screen = on_x && on_y;
      r.pixel_col = r.on_screen ? cx : '0;
      r.pixel_row = r.on_screen ? cy : '0;
      return r;
   endfunction

   function automatic void apply_setting(logic [1:0] idx, logic [31:0] val);
      case (idx)
         hapg_pkg::CSR_COEF_A:      set_a = val;
         hapg_pkg::CSR_COEF_B:      set_b = val;
         hapg_pkg::CSR_COEF_C:      set_c = val;
         hapg_pkg::CSR_PIXEL_SCALE: set_scale = val[3:0];
         default:                   ;
      endcase
   endfunction

   function automatic logic [31:0] pick_coef(setting_kind_type kind, logic [31:0] base);
      case (kind)
         SET_NEAR: return base + $urandom_range(0, 131071) - 32'd65536;
         SET_WILD: return $urandom();
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               default: return hapg_pkg::ONE_Q16;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_scale(setting_kind_type kind);
      case (kind)
         SET_NEAR: return $urandom_range(1, 8);
         // junk in the upper bits, any nibble
         SET_WILD: return $urandom();
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'd0;
               1:       return 32'd1;
               2:       return 32'd8;
               default: return 32'd15;
            endcase
         end
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge with req_valid still high
   task automatic send_item(input bit rst, input bit typed, input pixel_point_type typed_rsp);
      pixel_point_type p;
      req_valid <= 1'b1;
      req_restart <= rst;
      do @(posedge clock); while (req_stall);
      p = next_orbit_point(rst);
      pending_points.push_back(typed ? typed_rsp : p);
      items_sent++;
      if (rst) begin
         restarts_sent++;
      end
      @(negedge clock);
   endtask

   task automatic pause_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_setting(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic flag_mismatch(string field, longint want, longint got);
      errors++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_points.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall pattern, switching at random among the four stall modes
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(50, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= ((cycle_count % 16) < 5);
      endcase
   end

   always @(posedge clock) begin : result_check
      pixel_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            errors++;
            $error("unexpected result: point_x %0d point_y %0d", rsp_point_x, rsp_point_y);
         end else begin
            want = pending_points.pop_front();
            results_checked++;
            if (rsp_on_screen === 1'b1) begin
               on_screen_seen++;
            end
            if (rsp_point_x !== want.point_x) begin
               flag_mismatch("point_x", want.point_x, rsp_point_x);
            end
            if (rsp_point_y !== want.point_y) begin
               flag_mismatch("point_y", want.point_y, rsp_point_y);
            end
            if (rsp_pixel_col !== want.pixel_col) begin
               flag_mismatch("pixel_col", want.pixel_col, rsp_pixel_col);
            end
            if (rsp_pixel_row !== want.pixel_row) begin
               flag_mismatch("pixel_row", want.pixel_row, rsp_pixel_row);
            end
            if (rsp_on_screen !== want.on_screen) begin
               flag_mismatch("on_screen", want.on_screen, rsp_on_screen);
            end
         end
      end
   end

   initial begin : stimulus
      dir_row_type      row;
      setting_kind_type kind;
      int               n_items;
      int               burst;
      int               rand_items;
      bit               quiet;
      bit               rst;
      int               pick;

      // restart from reset, then the first step from x = 1.0 drops the root term
      dir_rows.push_back('{ROW_ITEM, 1'b1, hapg_pkg::CSR_COEF_A, 32'd0, 1'b1, HOME_PT});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b1, hapg_pkg::CSR_COEF_A, 32'd0, 1'b1, HOME_PT});
      // most negative a drives y to the floor, far off screen
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_COEF_A, 32'h8000_0000, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b1, hapg_pkg::CSR_COEF_A, 32'd0, 1'b1, HOME_PT});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b1,
                           '{32'sd0, 32'sh8000_0000, 11'd0, 11'd0, 1'b0}});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_COEF_A, 32'h7FFF_FFFF, 1'b0, '0});
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_COEF_B, 32'h8000_0000, 1'b0, '0});
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_COEF_C, 32'h7FFF_FFFF, 1'b0, '0});
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_PIXEL_SCALE, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b1, hapg_pkg::CSR_COEF_A, 32'd0, 1'b1,
                           '{32'sd65536, 32'sd65536, 11'd500, 11'd325, 1'b1}});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_COEF_B, 32'h7FFF_FFFF, 1'b0, '0});
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_COEF_C, 32'h8000_0000, 1'b0, '0});
      // only the low nibble of the scale register counts
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_PIXEL_SCALE, 32'hFFFF_FFFF, 1'b0,
                           '0});
      dir_rows.push_back('{ROW_ITEM, 1'b1, hapg_pkg::CSR_COEF_A, 32'd0, 1'b1,
                           '{32'sd65536, 32'sd65536, 11'd515, 11'd340, 1'b1}});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ROW_CSR, 1'b0, hapg_pkg::CSR_PIXEL_SCALE, 32'd8, 1'b0, '0});
      dir_rows.push_back('{ROW_ITEM, 1'b0, hapg_pkg::CSR_COEF_A, 32'd0, 1'b0, '0});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_drain();
            csr_write(row.csr_idx, row.csr_val);
         end else begin
            pick = $urandom_range(0, 2);
            if (pick != 0) begin
               pause_sender(pick);
            end
            send_item(row.restart, row.typed, row.rsp);
         end
      end
      settings_tried = 4;

      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         // every setting change waits for the block to go idle
         wait_drain();
         pick = $urandom_range(0, 19);
         kind = (pick < 12) ? SET_NEAR : (pick < 17) ? SET_WILD : SET_EDGE;
         if ($urandom_range(0, 3) != 0) begin
            csr_write(hapg_pkg::CSR_COEF_A, pick_coef(kind, hapg_pkg::RESET_COEF_A));
         end
         if ($urandom_range(0, 3) != 0) begin
            csr_write(hapg_pkg::CSR_COEF_B, pick_coef(kind, hapg_pkg::RESET_COEF_B));
         end
         if ($urandom_range(0, 3) != 0) begin
            csr_write(hapg_pkg::CSR_COEF_C, pick_coef(kind, hapg_pkg::RESET_COEF_C));
         end
         if ($urandom_range(0, 3) != 0) begin
            csr_write(hapg_pkg::CSR_PIXEL_SCALE, pick_scale(kind));
         end
         settings_tried++;

         n_items = $urandom_range(20, 80);
         quiet = ($urandom_range(0, 3) == 0);
         burst = 0;
         for (int k = 0; k < n_items; k++) begin
            // mostly long orbits from a fresh start, with an odd restart mid-orbit
            rst = (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 19) == 0);
            if (!quiet && burst == 0) begin
               pause_sender($urandom_range(1, 12));
               burst = $urandom_range(1, 16);
            end
            send_item(rst, 1'b0, '0);
            burst--;
            rand_items++;
         end
      end

      wait_drain();
      repeat (40) @(posedge clock);
      $display("run: %0d items (%0d restarts) over %0d coefficient settings",
               items_sent, restarts_sent, settings_tried);
      $display("run: %0d results checked, %0d on screen, %0d errors",
               results_checked, on_screen_seen, errors);
      if (errors == 0 && pending_points.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
